// ----- rtl/sdpt_pkg.sv -----
package sdpt_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int DIST_BITS_DEF  = 24;

  // grid registers come out of reset at full size
  localparam logic [8:0] GRID_RESET = 9'd256;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_TRACE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_STUCK = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // neighbour offsets in scan order, two's complement
  localparam logic [1:0] NB_DX [8] = '{2'b11, 2'b11, 2'b11, 2'b01,
                                       2'b01, 2'b01, 2'b00, 2'b00};
  localparam logic [1:0] NB_DY [8] = '{2'b11, 2'b01, 2'b00, 2'b11,
                                       2'b01, 2'b00, 2'b11, 2'b01};

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [23:0] dist_value;
  } sdpt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        mark;
    logic [15:0] step_count;
  } sdpt_out_t;

endpackage

// ----- rtl/sdpt_ram.sv -----
module sdpt_ram #(
  parameter int W  = 24,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/steepest_descent_path_tracer.sv -----
// Steepest-descent path tracer over an 8-connected distance map.
// Input channel (in_valid/in_stall/in_data) takes load, trace and read
// requests; every load, trace or read gives exactly one result on the
// output channel (out_valid/out_stall/out_data), request code 3 gives none.
// Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the grid
// width and height and are taken at any time; issue them while idle.
// Load and out-of-grid requests write their result straight into the output
// register; a read first passes through the mark-read state. A trace reads,
// for each move and for the final cell, the current cell and its eight
// neighbours one per cycle through the single read port of the distance memory.
// One request is in work at a time; the next one is taken once the
// previous result is in the output register and that register is free or
// being drained.
// After reset the path-mark memory is swept clear, one cell per cycle, over
// MAX_WIDTH*MAX_HEIGHT cells with each dimension rounded up to a power of two
// (65536 cells at the default size); in_stall stays high for the whole sweep.
// While out_stall is high the result holds in the output register and no
// new request is taken while it waits.
module steepest_descent_path_tracer #(
  parameter int MAX_WIDTH  = sdpt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sdpt_pkg::MAX_HEIGHT_DEF,
  parameter int DIST_BITS  = sdpt_pkg::DIST_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdpt_pkg::sdpt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sdpt_pkg::sdpt_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_data
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int AW  = XW + YW;
  localparam int CWX = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
  localparam int CWY = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
  localparam int CW  = (CWX > CWY) ? CWX : CWY;

  localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};
  localparam logic [3:0] SLOT_HERE = 4'd0;
  localparam logic [3:0] SLOT_DONE = 4'd9;
  localparam logic [15:0] STEP_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_MREAD = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [8:0]          cfg_w_r, cfg_w_nxt;
  logic [8:0]          cfg_h_r, cfg_h_nxt;
  logic                out_valid_r, out_valid_nxt;
  sdpt_pkg::sdpt_out_t out_data_r, out_data_nxt;

  logic [XW-1:0]        cur_x_r, cur_x_nxt;
  logic [YW-1:0]        cur_y_r, cur_y_nxt;
  logic [3:0]           issue_r, issue_nxt;
  logic                 pend_r, pend_nxt;
  logic                 pend_here_r, pend_here_nxt;
  logic                 pend_in_r, pend_in_nxt;
  logic [XW-1:0]        pend_x_r, pend_x_nxt;
  logic [YW-1:0]        pend_y_r, pend_y_nxt;
  logic [DIST_BITS-1:0] best_r, best_nxt;
  logic [XW-1:0]        best_x_r, best_x_nxt;
  logic [YW-1:0]        best_y_r, best_y_nxt;
  logic                 found_r, found_nxt;
  logic                 zero_r, zero_nxt;
  logic [15:0]          steps_r, steps_nxt;

  logic [CW-1:0]        eff_w, eff_h;
  logic [CW-1:0]        in_x, in_y;
  logic                 in_acc, in_range;
  logic [AW-1:0]        in_addr;
  logic [2:0]           nb_idx;
  logic [CW-1:0]        iss_x, iss_y;
  logic                 iss_in;
  logic [DIST_BITS-1:0] nd;

  logic                 dist_we;
  logic [AW-1:0]        dist_raddr;
  logic [DIST_BITS-1:0] dist_rdata;
  logic                 mark_we, mark_wdata, mark_rdata;
  logic [AW-1:0]        mark_waddr;

  // effective grid size: zero acts as one, above the maximum clamps
  always_comb begin
    if (cfg_w_r == 9'd0) begin
      eff_w = CW'(1);
    end else if (CW'(cfg_w_r) > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(cfg_w_r);
    end
    if (cfg_h_r == 9'd0) begin
      eff_h = CW'(1);
    end else if (CW'(cfg_h_r) > CW'(MAX_HEIGHT)) begin
      eff_h = CW'(MAX_HEIGHT);
    end else begin
      eff_h = CW'(cfg_h_r);
    end
  end

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_x     = CW'(in_data.cell_x);
  assign in_y     = CW'(in_data.cell_y);
  assign in_range = (in_x < eff_w) && (in_y < eff_h);
  assign in_addr  = {in_y[YW-1:0], in_x[XW-1:0]};

  // coordinates of the cell read in this scan slot; slot 0 is the cell itself
  assign nb_idx = 3'(issue_r - 4'd1);
  always_comb begin
    if (issue_r == SLOT_HERE) begin
      iss_x = CW'(cur_x_r);
      iss_y = CW'(cur_y_r);
    end else begin
      iss_x = CW'(cur_x_r) + {{(CW-2){sdpt_pkg::NB_DX[nb_idx][1]}}, sdpt_pkg::NB_DX[nb_idx]};
      iss_y = CW'(cur_y_r) + {{(CW-2){sdpt_pkg::NB_DY[nb_idx][1]}}, sdpt_pkg::NB_DY[nb_idx]};
    end
  end
  // a step below zero wraps high, so one compare covers both edges
  assign iss_in     = (iss_x < eff_w) && (iss_y < eff_h);
  assign dist_raddr = {iss_y[YW-1:0], iss_x[XW-1:0]};
  assign nd         = pend_in_r ? dist_rdata : DIST_INF;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cfg_w_nxt     = cfg_w_r;
    cfg_h_nxt     = cfg_h_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    pend_here_nxt = pend_here_r;
    pend_in_nxt   = pend_in_r;
    pend_x_nxt    = pend_x_r;
    pend_y_nxt    = pend_y_r;
    best_nxt      = best_r;
    best_x_nxt    = best_x_r;
    best_y_nxt    = best_y_r;
    found_nxt     = found_r;
    zero_nxt      = zero_r;
    steps_nxt     = steps_r;
    dist_we       = 1'b0;
    mark_we       = 1'b0;
    mark_waddr    = clr_r;
    mark_wdata    = 1'b0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sdpt_pkg::CFG_GRID_WIDTH:  cfg_w_nxt = cfg_data;
        sdpt_pkg::CFG_GRID_HEIGHT: cfg_h_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        mark_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc && in_data.req_type != sdpt_pkg::REQ_NONE) begin
          if (!in_range) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.status     = sdpt_pkg::ST_RANGE;
            out_data_nxt.mark       = 1'b0;
            out_data_nxt.step_count = 16'd0;
          end else begin
            unique case (in_data.req_type)
              sdpt_pkg::REQ_LOAD: begin
                dist_we                 = 1'b1;
                out_valid_nxt           = 1'b1;
                out_data_nxt.status     = sdpt_pkg::ST_OK;
                out_data_nxt.mark       = 1'b0;
                out_data_nxt.step_count = 16'd0;
              end
              sdpt_pkg::REQ_TRACE: begin
                mark_we    = 1'b1;
                mark_waddr = in_addr;
                mark_wdata = 1'b1;
                cur_x_nxt  = in_x[XW-1:0];
                cur_y_nxt  = in_y[YW-1:0];
                steps_nxt  = 16'd0;
                issue_nxt  = SLOT_HERE;
                state_nxt  = S_SCAN;
              end
              default: begin
                state_nxt = S_MREAD;
              end
            endcase
          end
        end
      end
      S_MREAD: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.status     = sdpt_pkg::ST_OK;
        out_data_nxt.mark       = mark_rdata;
        out_data_nxt.step_count = 16'd0;
        state_nxt               = S_IDLE;
      end
      S_SCAN: begin
        // read side: one cell per cycle
        if (issue_r != SLOT_DONE) begin
          pend_nxt      = 1'b1;
          pend_here_nxt = (issue_r == SLOT_HERE);
          pend_in_nxt   = (issue_r == SLOT_HERE) || iss_in;
          pend_x_nxt    = iss_x[XW-1:0];
          pend_y_nxt    = iss_y[YW-1:0];
          issue_nxt     = issue_r + 4'd1;
        end
        // compare side: data of the slot issued in the previous cycle
        if (pend_r) begin
          if (pend_here_r) begin
            best_nxt  = dist_rdata;
            zero_nxt  = (dist_rdata == '0);
            found_nxt = 1'b0;
          end else if (nd < best_r) begin
            best_nxt   = nd;
            best_x_nxt = pend_x_r;
            best_y_nxt = pend_y_r;
            found_nxt  = 1'b1;
          end
        end
        // all nine slots compared: stop or move
        if (issue_r == SLOT_DONE && !pend_r) begin
          if (zero_r || !found_r) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.status     = zero_r ? sdpt_pkg::ST_OK : sdpt_pkg::ST_STUCK;
            out_data_nxt.mark       = 1'b0;
            out_data_nxt.step_count = steps_r;
            state_nxt               = S_IDLE;
          end else begin
            cur_x_nxt  = best_x_r;
            cur_y_nxt  = best_y_r;
            mark_we    = 1'b1;
            mark_waddr = {best_y_r, best_x_r};
            mark_wdata = 1'b1;
            steps_nxt  = (steps_r == STEP_MAX) ? steps_r : steps_r + 16'd1;
            issue_nxt  = SLOT_HERE;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cfg_w_r     <= sdpt_pkg::GRID_RESET;
      cfg_h_r     <= sdpt_pkg::GRID_RESET;
      out_valid_r <= 1'b0;
      issue_r     <= SLOT_HERE;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cfg_w_r     <= cfg_w_nxt;
      cfg_h_r     <= cfg_h_nxt;
      out_valid_r <= out_valid_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    pend_here_r <= pend_here_nxt;
    pend_in_r   <= pend_in_nxt;
    pend_x_r    <= pend_x_nxt;
    pend_y_r    <= pend_y_nxt;
    best_r      <= best_nxt;
    best_x_r    <= best_x_nxt;
    best_y_r    <= best_y_nxt;
    found_r     <= found_nxt;
    zero_r      <= zero_nxt;
    steps_r     <= steps_nxt;
  end

  sdpt_ram #(
    .W  (DIST_BITS),
    .AW (AW)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (in_addr),
    .wdata (DIST_BITS'(in_data.dist_value)),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  sdpt_ram #(
    .W  (1),
    .AW (AW)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (in_addr),
    .rdata (mark_rdata)
  );

endmodule

// ----- rtl/sdpt_checker.sv -----
module sdpt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input sdpt_pkg::sdpt_out_t out_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the output and blocks input for the mark sweep
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("output or input live right after reset");

  // out-of-grid results carry nothing else
  a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sdpt_pkg::ST_RANGE |->
      !out_data.mark && out_data.step_count == 16'd0)
    else $error("out-of-grid result carries data");

  // a set mark only comes from a read, which takes no steps
  a_mark_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mark |->
      out_data.status == sdpt_pkg::ST_OK && out_data.step_count == 16'd0)
    else $error("mark set on a non-read result");

endmodule

bind steepest_descent_path_tracer sdpt_checker u_sdpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int COLS_MAX = sdpt_pkg::MAX_WIDTH_DEF;
  localparam int ROWS_MAX = sdpt_pkg::MAX_HEIGHT_DEF;
  localparam int CELL_COUNT = COLS_MAX * ROWS_MAX;
  localparam logic [23:0] DIST_INF = '1;
  localparam int RANDOM_ITEMS = 220;

  typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;
  typedef enum int {SHAPE_CONE, SHAPE_NOISE, SHAPE_PITTED, SHAPE_FLAT, SHAPE_RAMP} shape_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sdpt_pkg::sdpt_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sdpt_pkg::sdpt_out_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = 1'b0;
  logic [8:0]          cfg_data = '0;

  // mirror of the map, the marks and the grid registers
  logic [23:0]         dist_mem [CELL_COUNT];
  bit                  mark_mem [CELL_COUNT];
  bit                  loaded [CELL_COUNT];
  logic [8:0]          width_reg = sdpt_pkg::GRID_RESET;
  logic [8:0]          height_reg = sdpt_pkg::GRID_RESET;
  sdpt_pkg::sdpt_out_t expected_results [$];

  int errors = 0;
  int n_loads = 0;
  int n_traces = 0;
  int n_stuck = 0;
  int n_reads = 0;
  int n_outside = 0;
  int n_ignored = 0;
  int n_reg_writes = 0;
  int longest_walk = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int stall_hold = 0;

  steepest_descent_path_tracer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int cols_in_use();
    if (width_reg == 0) return 1;
    if (width_reg > COLS_MAX) return COLS_MAX;
    return int'(width_reg);
  endfunction

  function automatic int rows_in_use();
    if (height_reg == 0) return 1;
    if (height_reg > ROWS_MAX) return ROWS_MAX;
    return int'(height_reg);
  endfunction

  function automatic int cell_addr(input int x, input int y);
    return y * COLS_MAX + x;
  endfunction

  function automatic bit on_grid(input int x, input int y);
    return x >= 0 && y >= 0 && x < cols_in_use() && y < rows_in_use();
  endfunction

  // strictly smaller neighbour in scan order, first one wins ties
  function automatic bit downhill(input int x, input int y, output int bx, output int by);
    logic [23:0] best;
    logic [23:0] nd;
    int nx;
    int ny;
    int j;
    bit found;
    best = dist_mem[cell_addr(x, y)];
    bx = x;
    by = y;
    found = 1'b0;
    for (j = 0; j < 8; j++) begin
      nx = x + $signed(sdpt_pkg::NB_DX[j]);
      ny = y + $signed(sdpt_pkg::NB_DY[j]);
      nd = on_grid(nx, ny) ? dist_mem[cell_addr(nx, ny)] : DIST_INF;
      if (nd < best) begin
        best = nd;
        bx = nx;
        by = ny;
        found = 1'b1;
      end
    end
    return found;
  endfunction

  // a walk may only touch cells whose distance has been loaded
  function automatic bit walk_is_clean(input int sx, input int sy);
    int x;
    int y;
    int bx;
    int by;
    int dx;
    int dy;
    x = sx;
    y = sy;
    while (1) begin
      for (dy = -1; dy <= 1; dy++) begin
        for (dx = -1; dx <= 1; dx++) begin
          if (on_grid(x + dx, y + dy) && !loaded[cell_addr(x + dx, y + dy)]) return 1'b0;
        end
      end
      if (dist_mem[cell_addr(x, y)] == 0) return 1'b1;
      if (!downhill(x, y, bx, by)) return 1'b1;
      x = bx;
      y = by;
    end
  endfunction

  function automatic void model_accept(input sdpt_pkg::sdpt_in_t rq);
    sdpt_pkg::sdpt_out_t res;
    int x;
    int y;
    int bx;
    int by;
    int steps;
    x = rq.cell_x;
    y = rq.cell_y;
    res = '0;
    if (rq.req_type == sdpt_pkg::REQ_NONE) begin
      n_ignored++;
      return;
    end
    if (!on_grid(x, y)) begin
      res.status = sdpt_pkg::ST_RANGE;
      n_outside++;
    end else begin
      case (rq.req_type)
        sdpt_pkg::REQ_LOAD: begin
          dist_mem[cell_addr(x, y)] = rq.dist_value;
          loaded[cell_addr(x, y)] = 1'b1;
          n_loads++;
        end
        sdpt_pkg::REQ_READ: begin
          res.mark = mark_mem[cell_addr(x, y)];
          n_reads++;
        end
        default: begin
          steps = 0;
          mark_mem[cell_addr(x, y)] = 1'b1;
          while (dist_mem[cell_addr(x, y)] != 0) begin
            if (!downhill(x, y, bx, by)) begin
              res.status = sdpt_pkg::ST_STUCK;
              break;
            end
            x = bx;
            y = by;
            mark_mem[cell_addr(x, y)] = 1'b1;
            if (steps < 65535) steps++;
          end
          res.step_count = 16'(steps);
          n_traces++;
          if (res.status == sdpt_pkg::ST_STUCK) n_stuck++;
          if (steps > longest_walk) longest_walk = steps;
        end
      endcase
    end
    expected_results.push_back(res);
  endfunction

  always @(posedge clk) begin : result_check
    sdpt_pkg::sdpt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $error("result with none expected: status %0d mark %0d step_count %0d",
               out_data.status, out_data.mark, out_data.step_count);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status) begin
          errors++;
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
        end
        if (out_data.mark !== want.mark) begin
          errors++;
          $error("mark: expected %0d, actual %0d", want.mark, out_data.mark);
        end
        if (out_data.step_count !== want.step_count) begin
          errors++;
          $error("step_count: expected %0d, actual %0d", want.step_count, out_data.step_count);
        end
      end
    end
  end

  // receiver side; a long hold is counted down here
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold = stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_request(input logic [1:0] kind, input int x, input int y,
                              input logic [23:0] d);
    sdpt_pkg::sdpt_in_t rq;
    rq.req_type = kind;
    rq.cell_x = 8'(x);
    rq.cell_y = 8'(y);
    rq.dist_value = d;
    if (kind == sdpt_pkg::REQ_TRACE && on_grid(x, y) && !walk_is_clean(x, y)) begin
      rq.req_type = sdpt_pkg::REQ_READ;
    end
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_accept(rq);
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == sdpt_pkg::CFG_GRID_WIDTH) width_reg = val;
    else height_reg = val;
    n_reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(input logic [8:0] w, input logic [8:0] h);
    settle();
    write_reg(sdpt_pkg::CFG_GRID_WIDTH, w);
    write_reg(sdpt_pkg::CFG_GRID_HEIGHT, h);
  endtask

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_FULL: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      PACE_SEND_IDLE: begin
        send_idle_pct = 72;
        stall_pct = 0;
      end
      PACE_RECV_STALL: begin
        send_idle_pct = 0;
        stall_pct = 72;
      end
      default: begin
        send_idle_pct = 26;
        stall_pct = 26;
      end
    endcase
  endtask

  function automatic logic [23:0] map_value(input shape_t shape, input int x, input int y,
                                            input int tx, input int ty, input int scale);
    int ax;
    int ay;
    int cheb;
    ax = (x > tx) ? x - tx : tx - x;
    ay = (y > ty) ? y - ty : ty - y;
    cheb = (ax > ay) ? ax : ay;
    case (shape)
      SHAPE_CONE:   return 24'(cheb * scale);
      SHAPE_NOISE:  return 24'($urandom);
      SHAPE_PITTED: begin
        if ($urandom_range(0, 7) == 0) return DIST_INF;
        return 24'(cheb * scale + $urandom_range(0, scale));
      end
      SHAPE_FLAT:   return 24'($urandom_range(0, 3));
      default:      return 24'((x + 16 * y) * scale);
    endcase
  endfunction

  // full-size grid from reset, only the far corner in use
  task automatic test_corner_cells();
    send_request(sdpt_pkg::REQ_LOAD, 255, 255, 24'd0);
    send_request(sdpt_pkg::REQ_LOAD, 254, 254, DIST_INF);
    send_request(sdpt_pkg::REQ_LOAD, 254, 255, 24'd1);
    send_request(sdpt_pkg::REQ_LOAD, 255, 254, 24'h800000);
    send_request(sdpt_pkg::REQ_TRACE, 255, 255, 24'd0);
    send_request(sdpt_pkg::REQ_READ, 255, 255, 24'd0);
    send_request(sdpt_pkg::REQ_READ, 254, 255, 24'd0);
    send_request(sdpt_pkg::REQ_NONE, 255, 255, DIST_INF);
  endtask

  // 3x3 map: infinite start, walk to a zero cell, first minimum wins, stuck cell
  task automatic test_small_map();
    logic [23:0] cells [9];
    int k;
    cells = '{24'd5, DIST_INF, 24'd0, 24'd3, 24'd3, DIST_INF, DIST_INF, 24'd1, 24'd7};
    set_grid(9'd3, 9'd3);
    for (k = 0; k < 9; k++) send_request(sdpt_pkg::REQ_LOAD, k % 3, k / 3, cells[k]);
    send_request(sdpt_pkg::REQ_LOAD, 3, 0, 24'd9);
    send_request(sdpt_pkg::REQ_TRACE, 0, 3, 24'd0);
    send_request(sdpt_pkg::REQ_READ, 255, 255, 24'd0);
    send_request(sdpt_pkg::REQ_NONE, 0, 0, 24'd0);
    send_request(sdpt_pkg::REQ_TRACE, 1, 0, 24'd0);
    send_request(sdpt_pkg::REQ_TRACE, 0, 0, 24'd0);
    send_request(sdpt_pkg::REQ_TRACE, 1, 2, 24'd0);
    send_request(sdpt_pkg::REQ_TRACE, 2, 2, 24'd0);
    send_request(sdpt_pkg::REQ_READ, 1, 1, 24'd0);
    send_request(sdpt_pkg::REQ_READ, 0, 2, 24'd0);
    send_request(sdpt_pkg::REQ_READ, 2, 0, 24'd0);
  endtask

  // zero and oversize register values, single cell grid, resize back
  task automatic test_register_extremes();
    set_grid(9'd0, 9'd511);
    send_request(sdpt_pkg::REQ_LOAD, 0, 254, DIST_INF);
    send_request(sdpt_pkg::REQ_LOAD, 0, 255, 24'd5);
    send_request(sdpt_pkg::REQ_TRACE, 0, 255, 24'd0);
    send_request(sdpt_pkg::REQ_READ, 1, 0, 24'd0);
    send_request(sdpt_pkg::REQ_READ, 0, 255, 24'd0);
    set_grid(9'd511, 9'd0);
    send_request(sdpt_pkg::REQ_LOAD, 253, 0, DIST_INF);
    send_request(sdpt_pkg::REQ_LOAD, 254, 0, 24'd9);
    send_request(sdpt_pkg::REQ_LOAD, 255, 0, 24'd0);
    send_request(sdpt_pkg::REQ_TRACE, 254, 0, 24'd0);
    send_request(sdpt_pkg::REQ_TRACE, 0, 1, 24'd0);
    set_grid(9'd1, 9'd1);
    send_request(sdpt_pkg::REQ_LOAD, 0, 0, DIST_INF);
    send_request(sdpt_pkg::REQ_TRACE, 0, 0, 24'd0);
    send_request(sdpt_pkg::REQ_READ, 0, 0, 24'd0);
    send_request(sdpt_pkg::REQ_LOAD, 1, 0, 24'd0);
    set_grid(9'd256, 9'd256);
    send_request(sdpt_pkg::REQ_READ, 255, 255, 24'd0);
    send_request(sdpt_pkg::REQ_READ, 255, 0, 24'd0);
  endtask

  // output held off while loads keep coming, then traces after a full drain
  task automatic test_backpressure();
    int k;
    set_grid(9'd8, 9'd2);
    set_pace(PACE_FULL);
    stall_hold = 400;
    for (k = 0; k < 16; k++) begin
      send_request(sdpt_pkg::REQ_LOAD, k % 8, k / 8, 24'($urandom_range(0, 40)));
    end
    settle();
    stall_hold = 120;
    for (k = 0; k < 6; k++)
      send_request(sdpt_pkg::REQ_TRACE, $urandom_range(0, 7), $urandom_range(0, 1), 24'd0);
    settle();
  endtask

  task automatic test_random_maps();
    int phase;
    int random_items;
    int w_val;
    int h_val;
    int cols;
    int rows;
    int tx;
    int ty;
    int scale;
    int ops;
    int r;
    int x;
    int y;
    logic [1:0] kind;
    logic [23:0] d;
    shape_t shape;
    phase = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        w_val = $urandom_range(256, 511);
        h_val = $urandom_range(0, 2);
      end else if (r == 1) begin
        w_val = $urandom_range(0, 2);
        h_val = $urandom_range(256, 511);
      end else begin
        w_val = $urandom_range(1, 12);
        h_val = $urandom_range(0, (48 / w_val > 12) ? 12 : 48 / w_val);
      end
      set_grid(9'(w_val), 9'(h_val));
      set_pace(pace_t'(phase % 4));
      cols = cols_in_use();
      rows = rows_in_use();
      tx = $urandom_range(0, cols - 1);
      ty = $urandom_range(0, rows - 1);
      shape = shape_t'($urandom_range(0, 4));
      scale = $urandom_range(1, 50000);
      if (cols * rows <= 64) begin
        // now and then keep the old map to see stored cells survive a resize
        if ($urandom_range(0, 3) != 0) begin
          for (y = 0; y < rows; y++) begin
            for (x = 0; x < cols; x++) begin
              send_request(sdpt_pkg::REQ_LOAD, x, y, map_value(shape, x, y, tx, ty, scale));
              random_items++;
            end
          end
        end
      end else begin
        repeat (16) begin
          x = $urandom_range(0, cols - 1);
          y = $urandom_range(0, rows - 1);
          send_request(sdpt_pkg::REQ_LOAD, x, y, map_value(shape, x, y, tx, ty, scale));
          random_items++;
        end
      end
      ops = $urandom_range(15, 30);
      repeat (ops) begin
        r = $urandom_range(0, 99);
        x = $urandom_range(0, cols - 1);
        y = $urandom_range(0, rows - 1);
        d = $urandom_range(0, 1) ? map_value(shape, x, y, tx, ty, scale) : 24'($urandom);
        if (r < 45) begin
          kind = sdpt_pkg::REQ_TRACE;
        end else if (r < 65) begin
          kind = sdpt_pkg::REQ_READ;
        end else if (r < 75) begin
          kind = sdpt_pkg::REQ_LOAD;
        end else if (r < 92) begin
          kind = 2'($urandom_range(0, 2));
          if (cols < COLS_MAX && (rows == ROWS_MAX || $urandom_range(0, 1) == 1)) begin
            x = $urandom_range(cols, 255);
            y = $urandom_range(0, 255);
          end else if (rows < ROWS_MAX) begin
            x = $urandom_range(0, 255);
            y = $urandom_range(rows, 255);
          end else begin
            kind = sdpt_pkg::REQ_READ;
          end
        end else begin
          kind = sdpt_pkg::REQ_NONE;
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end
        send_request(kind, x, y, d);
        if (kind != sdpt_pkg::REQ_NONE) random_items++;
      end
      phase++;
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_corner_cells();
    test_small_map();
    test_register_extremes();
    test_backpressure();
    test_random_maps();
    settle();
    repeat (64) @(posedge clk);
    $display("covered %0d loads, %0d mark reads, %0d traces (%0d stuck, longest %0d moves)",
             n_loads, n_reads, n_traces, n_stuck, longest_walk);
    $display("plus %0d out-of-grid requests, %0d ignored codes, %0d grid register writes",
             n_outside, n_ignored, n_reg_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // generous guard: the clearing sweep after reset plus every walk at its slowest
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
